// File: design/pls_pkg.sv
// Shared constants, types and helpers of the positional list store.
package pls_pkg;

   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;

   localparam int CMD_W    = 3;
   localparam int POS_W    = 5;
   localparam int PORT_W   = 32;
   localparam int STATUS_W = 2;
   localparam int FIDX_W   = 4;
   localparam int FCNT_W   = 5;

   localparam int COUNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMP_W   = (COUNT_W > POS_W) ? COUNT_W : POS_W;
   localparam int WIDE_W  = (DATA_WIDTH > PORT_W) ? DATA_WIDTH : PORT_W;
   localparam int FIDX_WIDE_W = (IDX_W > FIDX_W) ? IDX_W : FIDX_W;
   localparam int FCNT_WIDE_W = (COUNT_W > FCNT_W) ? COUNT_W : FCNT_W;

   localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REPLACE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_GET     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_MISS  = 2'd3;

   typedef logic [DATA_WIDTH-1:0] word_type;
   typedef logic [CMP_W-1:0]      place_type;

   typedef struct packed {
      logic                 valid;
      logic [CMD_W-1:0]     command;
      place_type            position;
      place_type            count;
      word_type             value;
      word_type             key;
   } cell_cmd_type;

   typedef struct packed {
      logic                 any;
      word_type             data;
      logic [IDX_W-1:0]     index;
   } tally_type;

   function automatic word_type port_to_word(input logic [PORT_W-1:0] port);
      logic [WIDE_W-1:0] wide;
      wide = WIDE_W'(port);
      return wide[DATA_WIDTH-1:0];
   endfunction

   function automatic logic [PORT_W-1:0] word_to_port(input word_type word);
      logic [WIDE_W-1:0] wide;
      wide = WIDE_W'(word);
      return wide[PORT_W-1:0];
   endfunction

endpackage

// File: design/pls_cell.sv
// One list entry: shifts with its neighbors and flags a position or key hit.
module pls_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  pls_pkg::cell_cmd_type cmd,
   input  pls_pkg::place_type    cell_index,
   input  pls_pkg::word_type     left_data,
   input  pls_pkg::word_type     right_data,
   output pls_pkg::word_type     data,
   output logic                  hit,
   output pls_pkg::word_type     old_data
);

   pls_pkg::word_type data_ff, data_in;
   pls_pkg::word_type old_ff;
   logic              hit_ff, hit_in;

   always_comb begin
      data_in = data_ff;
      hit_in  = 1'b0;
      if (cmd.valid) begin
         case (cmd.command)
            pls_pkg::CMD_INSERT: begin
               if (cell_index > cmd.position) begin
                  data_in = left_data;
               end else if (cell_index == cmd.position) begin
                  data_in = cmd.value;
               end
            end
            pls_pkg::CMD_REMOVE: begin
               hit_in = (cell_index == cmd.position);
               if (cell_index >= cmd.position) begin
                  data_in = right_data;
               end
            end
            pls_pkg::CMD_REPLACE: begin
               hit_in = (cell_index == cmd.position);
               if (hit_in) begin
                  data_in = cmd.value;
               end
            end
            pls_pkg::CMD_GET: begin
               hit_in = (cell_index == cmd.position);
            end
            pls_pkg::CMD_SEARCH: begin
               hit_in = (cell_index < cmd.count) && (data_ff == cmd.key);
            end
            default: begin
               hit_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
      data_ff <= data_in;
      old_ff  <= data_ff;
   end

   assign data     = data_ff;
   assign hit      = hit_ff;
   assign old_data = old_ff;

endmodule

// File: design/pls_collect.sv
// Picks the first hit cell and gathers its word and index.
module pls_collect (
   input  logic [pls_pkg::CAPACITY-1:0] hits,
   input  pls_pkg::word_type            words [pls_pkg::CAPACITY],
   output pls_pkg::tally_type           tally
);

   logic [pls_pkg::CAPACITY-1:0] first;

   always_comb begin
      first       = hits & (~hits + 1'b1);
      tally.any   = |hits;
      tally.data  = '0;
      tally.index = '0;
      for (int i = 0; i < pls_pkg::CAPACITY; i++) begin
         if (first[i]) begin
            tally.data  = tally.data | words[i];
            tally.index = tally.index | pls_pkg::IDX_W'(i);
         end
      end
   end

endmodule

// File: design/positional_list_store.sv
// Positional list store: a row of entry cells with insert, remove, replace, get, search.
// A command accepted at one edge updates the cell registers and hit flags; the response
// registers then capture the gather and show it on the rsp_ ports for one cycle, with rsp_strobe high.
// busy covers the cell update and gather, so a new command waits until both are through.
// Reset clears the entry count and the handshake; entry words stay undefined.
// The receiver cannot stall: each word is shown once and taken at that edge.
module positional_list_store (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [pls_pkg::CMD_W-1:0]      req_command,
   input  logic [pls_pkg::POS_W-1:0]      req_position,
   input  logic [pls_pkg::PORT_W-1:0]     req_value,
   input  logic [pls_pkg::PORT_W-1:0]     req_search_key,
   output logic                           rsp_strobe,
   output logic [pls_pkg::STATUS_W-1:0]   rsp_status,
   output logic [pls_pkg::PORT_W-1:0]     rsp_data_out,
   output logic [pls_pkg::FIDX_W-1:0]     rsp_found_index,
   output logic [pls_pkg::FCNT_W-1:0]     rsp_entry_count,
   output logic                           rsp_is_empty
);

   localparam int CAP = pls_pkg::CAPACITY;

   logic                               busy_ff;
   logic [pls_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic [pls_pkg::STATUS_W-1:0]       status_ff, status_in;
   logic                               search_ff;
   logic                               strobe_ff;
   logic [pls_pkg::STATUS_W-1:0]       rsp_status_ff;
   logic [pls_pkg::PORT_W-1:0]         rsp_data_ff;
   logic [pls_pkg::FIDX_W-1:0]         rsp_index_ff;
   logic [pls_pkg::FCNT_W-1:0]         rsp_count_ff;
   logic                               rsp_empty_ff;

   logic                               accept;
   logic                               ok;
   pls_pkg::place_type                 pos, cnt;
   pls_pkg::cell_cmd_type              cmd;
   pls_pkg::word_type                  cell_data [CAP];
   pls_pkg::word_type                  cell_old  [CAP];
   logic [CAP-1:0]                     cell_hit;
   pls_pkg::tally_type                 tally;
   logic [pls_pkg::FIDX_WIDE_W-1:0]    index_wide;
   logic [pls_pkg::FCNT_WIDE_W-1:0]    count_wide;

   assign accept = start && !busy_ff;
   assign pos    = pls_pkg::CMP_W'(req_position);
   assign cnt    = pls_pkg::CMP_W'(count_ff);

   always_comb begin
      ok        = 1'b0;
      status_in = pls_pkg::ST_RANGE;
      count_in  = count_ff;
      case (req_command)
         pls_pkg::CMD_INSERT: begin
            if (pos > cnt) begin
               status_in = pls_pkg::ST_RANGE;
            end else if (cnt >= pls_pkg::CMP_W'(CAP)) begin
               status_in = pls_pkg::ST_FULL;
            end else begin
               ok        = 1'b1;
               status_in = pls_pkg::ST_DONE;
               count_in  = count_ff + 1'b1;
            end
         end
         pls_pkg::CMD_REMOVE: begin
            if (pos < cnt) begin
               ok        = 1'b1;
               status_in = pls_pkg::ST_DONE;
               count_in  = count_ff - 1'b1;
            end
         end
         pls_pkg::CMD_REPLACE, pls_pkg::CMD_GET: begin
            if (pos < cnt) begin
               ok        = 1'b1;
               status_in = pls_pkg::ST_DONE;
            end
         end
         pls_pkg::CMD_SEARCH: begin
            ok        = 1'b1;
            status_in = pls_pkg::ST_MISS;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      cmd.valid    = accept && ok;
      cmd.command  = req_command;
      cmd.position = pos;
      cmd.count    = cnt;
      cmd.value    = pls_pkg::port_to_word(req_value);
      cmd.key      = pls_pkg::port_to_word(req_search_key);
   end

   for (genvar i = 0; i < CAP; i++) begin : g_cell
      pls_pkg::word_type left_w, right_w;
      if (i == 0) begin : g_head
         assign left_w = '0;
      end else begin : g_left
         assign left_w = cell_data[i-1];
      end
      if (i == CAP - 1) begin : g_tail
         assign right_w = cell_data[i];
      end else begin : g_right
         assign right_w = cell_data[i+1];
      end
      pls_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .cell_index (pls_pkg::CMP_W'(i)),
         .left_data  (left_w),
         .right_data (right_w),
         .data       (cell_data[i]),
         .hit        (cell_hit[i]),
         .old_data   (cell_old[i])
      );
   end

   pls_collect u_collect (
      .hits  (cell_hit),
      .words (cell_old),
      .tally (tally)
   );

   assign index_wide = pls_pkg::FIDX_WIDE_W'(tally.index);
   assign count_wide = pls_pkg::FCNT_WIDE_W'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         busy_ff   <= accept;
         strobe_ff <= busy_ff;
         if (accept) begin
            count_ff <= count_in;
         end
      end
      if (accept) begin
         status_ff <= status_in;
         search_ff <= (req_command == pls_pkg::CMD_SEARCH);
      end
      if (busy_ff) begin
         rsp_data_ff  <= pls_pkg::word_to_port(tally.data);
         rsp_count_ff <= count_wide[pls_pkg::FCNT_W-1:0];
         rsp_empty_ff <= (count_ff == '0);
         if (search_ff && tally.any) begin
            rsp_status_ff <= pls_pkg::ST_DONE;
            rsp_index_ff  <= index_wide[pls_pkg::FIDX_W-1:0];
         end else begin
            rsp_status_ff <= status_ff;
            rsp_index_ff  <= '0;
         end
      end
   end

   assign busy            = busy_ff;
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_found_index = rsp_index_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for positional_list_store: queued commands, predicted answers.
module tb;

   localparam int LIMIT_CYCLES = 200000;
   localparam int PHASE_ITEMS  = 225;
   localparam int REPORT_MAX   = 10;
   localparam logic [pls_pkg::POS_W-1:0] POS_MAX = '1;
   localparam logic [pls_pkg::CMD_W-1:0] CMD_MAX = '1;

   typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_kind_type;

   typedef struct {
      logic [pls_pkg::CMD_W-1:0]  command;
      logic [pls_pkg::POS_W-1:0]  position;
      logic [pls_pkg::PORT_W-1:0] value;
      logic [pls_pkg::PORT_W-1:0] key;
      int                         idle_pct;
      bit                         drain;
   } list_cmd_type;

   typedef struct {
      logic [pls_pkg::STATUS_W-1:0] status;
      logic [pls_pkg::PORT_W-1:0]   data;
      logic [pls_pkg::FIDX_W-1:0]   fidx;
      logic [pls_pkg::FCNT_W-1:0]   count;
      logic                         empty;
   } list_answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [pls_pkg::CMD_W-1:0]  req_command    = '0;
   logic [pls_pkg::POS_W-1:0]  req_position   = '0;
   logic [pls_pkg::PORT_W-1:0] req_value      = '0;
   logic [pls_pkg::PORT_W-1:0] req_search_key = '0;
   logic                         rsp_strobe;
   logic [pls_pkg::STATUS_W-1:0] rsp_status;
   logic [pls_pkg::PORT_W-1:0]   rsp_data_out;
   logic [pls_pkg::FIDX_W-1:0]   rsp_found_index;
   logic [pls_pkg::FCNT_W-1:0]   rsp_entry_count;
   logic                         rsp_is_empty;

   list_cmd_type    pending_cmds[$];
   list_answer_type answers_due[$];

   pls_pkg::word_type list_words [pls_pkg::CAPACITY];
   int       list_len = 0;
   int       gen_len = 0;
   logic [pls_pkg::PORT_W-1:0] key_pool [8];

   int cycles = 0;
   int accepted = 0;
   int checked = 0;
   int faults = 0;
   int status_seen [4] = '{0, 0, 0, 0};

   positional_list_store u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_position    (req_position),
      .req_value       (req_value),
      .req_search_key  (req_search_key),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_data_out    (rsp_data_out),
      .rsp_found_index (rsp_found_index),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

   always #1 clock = ~clock;

   function automatic list_answer_type list_apply(input logic [pls_pkg::CMD_W-1:0] cmd,
                                                  input logic [pls_pkg::POS_W-1:0] pos,
                                                  input logic [pls_pkg::PORT_W-1:0] value,
                                                  input logic [pls_pkg::PORT_W-1:0] key);
      list_answer_type   ans;
      pls_pkg::word_type w;
      pls_pkg::word_type k;
      int                p;
      int                i;
      bit                hit;
      w = pls_pkg::word_type'(value);
      k = pls_pkg::word_type'(key);
      p = pos;
      hit = 1'b0;
      ans.status = pls_pkg::ST_RANGE;
      ans.data = '0;
      ans.fidx = '0;
      case (cmd)
         pls_pkg::CMD_INSERT: begin
            if (p > list_len) begin
               ans.status = pls_pkg::ST_RANGE;
            end else if (list_len >= pls_pkg::CAPACITY) begin
               ans.status = pls_pkg::ST_FULL;
            end else begin
               for (i = list_len; i > p; i--) list_words[i] = list_words[i-1];
               list_words[p] = w;
               list_len++;
               ans.status = pls_pkg::ST_DONE;
            end
         end
         pls_pkg::CMD_REMOVE: begin
            if (p < list_len) begin
               ans.data = pls_pkg::PORT_W'(list_words[p]);
               for (i = p; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
               list_len--;
               ans.status = pls_pkg::ST_DONE;
            end
         end
         pls_pkg::CMD_REPLACE: begin
            if (p < list_len) begin
               ans.data = pls_pkg::PORT_W'(list_words[p]);
               list_words[p] = w;
               ans.status = pls_pkg::ST_DONE;
            end
         end
         pls_pkg::CMD_GET: begin
            if (p < list_len) begin
               ans.data = pls_pkg::PORT_W'(list_words[p]);
               ans.status = pls_pkg::ST_DONE;
            end
         end
         pls_pkg::CMD_SEARCH: begin
            ans.status = pls_pkg::ST_MISS;
            for (i = 0; i < list_len && !hit; i++) begin
               if (list_words[i] == k) begin
                  hit = 1'b1;
                  ans.data = pls_pkg::PORT_W'(list_words[i]);
                  ans.fidx = pls_pkg::FIDX_W'(i);
                  ans.status = pls_pkg::ST_DONE;
               end
            end
         end
         default: ;
      endcase
      ans.count = pls_pkg::FCNT_W'(list_len);
      ans.empty = (list_len == 0);
      return ans;
   endfunction

   task automatic queue_cmd(input logic [pls_pkg::CMD_W-1:0] cmd,
                            input logic [pls_pkg::POS_W-1:0] pos,
                            input logic [pls_pkg::PORT_W-1:0] value,
                            input logic [pls_pkg::PORT_W-1:0] key,
                            input int idle_pct, input bit drain);
      list_cmd_type c;
      c.command = cmd;
      c.position = pos;
      c.value = value;
      c.key = key;
      c.idle_pct = idle_pct;
      c.drain = drain;
      pending_cmds.push_back(c);
      if (cmd == pls_pkg::CMD_INSERT && pos <= gen_len && gen_len < pls_pkg::CAPACITY)
         gen_len++;
      else if (cmd == pls_pkg::CMD_REMOVE && pos < gen_len)
         gen_len--;
   endtask

   task automatic queue_random(input burst_kind_type kind, input int idle_pct,
                               input bit drain);
      logic [pls_pkg::CMD_W-1:0]  cmd;
      logic [pls_pkg::POS_W-1:0]  pos;
      logic [pls_pkg::PORT_W-1:0] value;
      logic [pls_pkg::PORT_W-1:0] key;
      int                         roll;
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 8) begin
         cmd = pls_pkg::CMD_W'($urandom_range(0, CMD_MAX));
         pos = pls_pkg::POS_W'($urandom_range(0, POS_MAX));
      end else begin
         case (kind)
            BURST_FILL:
               cmd = (roll < 80) ? pls_pkg::CMD_INSERT :
                     pls_pkg::CMD_W'($urandom_range(pls_pkg::CMD_REMOVE, pls_pkg::CMD_SEARCH));
            BURST_DRAIN:
               cmd = (roll < 70) ? pls_pkg::CMD_REMOVE :
                     pls_pkg::CMD_W'($urandom_range(pls_pkg::CMD_INSERT, pls_pkg::CMD_SEARCH));
            default:
               cmd = pls_pkg::CMD_W'($urandom_range(pls_pkg::CMD_INSERT, pls_pkg::CMD_SEARCH));
         endcase
         if ($urandom_range(0, 99) < 10) begin
            pos = pls_pkg::POS_W'($urandom_range(0, POS_MAX));
         end else if (cmd == pls_pkg::CMD_INSERT) begin
            pos = pls_pkg::POS_W'($urandom_range(0, gen_len));
         end else if (gen_len > 0) begin
            pos = pls_pkg::POS_W'($urandom_range(0, gen_len - 1));
         end else begin
            pos = pls_pkg::POS_W'($urandom_range(0, 2));
         end
      end
      value = ($urandom_range(0, 1) == 0) ? key_pool[$urandom_range(0, 7)] : $urandom;
      key = ($urandom_range(0, 99) < 70) ? key_pool[$urandom_range(0, 7)] : $urandom;
      queue_cmd(cmd, pos, value, key, idle_pct, drain);
   endtask

   task automatic note_fault(input string what, input logic [pls_pkg::PORT_W-1:0] want,
                             input logic [pls_pkg::PORT_W-1:0] got);
      if (faults < REPORT_MAX)
         $display("mismatch at cycle %0d: %s expected %0h, got %0h", cycles, what, want, got);
      faults++;
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin : drive
      list_cmd_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            answers_due.push_back(list_apply(req_command, req_position, req_value,
                                             req_search_key));
            accepted++;
         end
         if (!start || !busy) begin
            if (pending_cmds.size() != 0 &&
                !(pending_cmds[0].drain && answers_due.size() != 0) &&
                $urandom_range(0, 99) >= pending_cmds[0].idle_pct) begin
               nxt = pending_cmds.pop_front();
               start <= 1'b1;
               req_command <= nxt.command;
               req_position <= nxt.position;
               req_value <= nxt.value;
               req_search_key <= nxt.key;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch
      list_answer_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (answers_due.size() == 0) begin
            note_fault("unexpected word, status", '0, pls_pkg::PORT_W'(rsp_status));
         end else begin
            want = answers_due.pop_front();
            checked++;
            status_seen[want.status]++;
            if (rsp_status !== want.status)
               note_fault("status", pls_pkg::PORT_W'(want.status),
                          pls_pkg::PORT_W'(rsp_status));
            if (rsp_data_out !== want.data)
               note_fault("data_out", want.data, rsp_data_out);
            if (rsp_found_index !== want.fidx)
               note_fault("found_index", pls_pkg::PORT_W'(want.fidx),
                          pls_pkg::PORT_W'(rsp_found_index));
            if (rsp_entry_count !== want.count)
               note_fault("entry_count", pls_pkg::PORT_W'(want.count),
                          pls_pkg::PORT_W'(rsp_entry_count));
            if (rsp_is_empty !== want.empty)
               note_fault("is_empty", pls_pkg::PORT_W'(want.empty),
                          pls_pkg::PORT_W'(rsp_is_empty));
         end
      end
   end

   initial begin
      int phase_idle [4];
      int phase;
      int burst;
      int n;
      int c;
      bit first;
      burst_kind_type kind;
      phase_idle = '{0, 67, 0, 27};
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (n = 2; n < 8; n++) key_pool[n] = $urandom;

      queue_cmd(pls_pkg::CMD_GET, 0, '0, '0, 0, 0);
      queue_cmd(pls_pkg::CMD_REMOVE, 0, '0, '0, 0, 0);
      queue_cmd(pls_pkg::CMD_REPLACE, 0, 32'hDEAD_BEEF, '0, 0, 0);
      queue_cmd(pls_pkg::CMD_SEARCH, 0, '0, '0, 0, 0);
      queue_cmd(pls_pkg::CMD_INSERT, 1, 32'h1111_1111, '0, 0, 0);
      queue_cmd(pls_pkg::CMD_INSERT, 0, '0, '0, 0, 0);
      queue_cmd(pls_pkg::CMD_INSERT, 1, '1, '0, 0, 0);
      queue_cmd(pls_pkg::CMD_INSERT, 0, 32'hA5A5_A5A5, '0, 0, 0);
      queue_cmd(pls_pkg::CMD_INSERT, 3, 32'h5A5A_5A5A, '1, 0, 0);
      queue_cmd(pls_pkg::CMD_INSERT, POS_MAX, '1, '1, 0, 0);
      queue_cmd(pls_pkg::CMD_SEARCH, 0, '0, '1, 0, 0);
      queue_cmd(pls_pkg::CMD_SEARCH, POS_MAX, '1, '0, 0, 0);
      queue_cmd(pls_pkg::CMD_SEARCH, 0, '0, 32'h1234_5678, 0, 0);
      queue_cmd(pls_pkg::CMD_GET, POS_MAX, '0, '0, 0, 0);
      queue_cmd(pls_pkg::CMD_GET, 4, '0, '0, 0, 0);
      queue_cmd(pls_pkg::CMD_GET, 3, '0, '0, 0, 0);
      queue_cmd(pls_pkg::CMD_REPLACE, 1, 32'h0F0F_0F0F, '0, 0, 0);
      queue_cmd(pls_pkg::CMD_REMOVE, 0, '0, '0, 0, 0);
      queue_cmd(pls_pkg::CMD_REMOVE, 3, '0, '0, 0, 0);
      queue_cmd(pls_pkg::CMD_REMOVE, 2, '0, '0, 0, 0);
      for (c = pls_pkg::CMD_SEARCH + 1; c <= CMD_MAX; c++)
         queue_cmd(pls_pkg::CMD_W'(c), pls_pkg::POS_W'(c), '1, '1, 0, 0);

      for (phase = 0; phase < 4; phase++) begin
         n = 0;
         first = 1'b1;
         while (n < PHASE_ITEMS) begin
            c = $urandom_range(0, 99);
            kind = (c < 40) ? BURST_FILL : (c < 70) ? BURST_DRAIN : BURST_MIXED;
            for (burst = $urandom_range(6, 40); burst > 0; burst--) begin
               queue_random(kind, phase_idle[phase], first);
               first = 1'b0;
               n++;
            end
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || start) @(posedge clock);
      while (answers_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (answers_due.size() != 0) begin
         $display("%0d expected words never arrived", answers_due.size());
         faults += answers_due.size();
      end

      $display("covered %0d commands, %0d answers compared, %0d faults", accepted, checked,
               faults);
      $display("answer mix: done %0d, out of range %0d, full %0d, not found %0d",
               status_seen[pls_pkg::ST_DONE], status_seen[pls_pkg::ST_RANGE],
               status_seen[pls_pkg::ST_FULL], status_seen[pls_pkg::ST_MISS]);
      if (faults == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
